@@ rtl/ilae_pkg.sv @@
// Shared types and codes of the indexed list array engine.
`timescale 1ns / 1ps

package ilae_pkg;

  localparam int WORD_W = 32;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_EDIT   = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [6:0] CAP_RESET = 7'd64;

  // What every cell of the chain does when it is clocked.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INS,
    CELL_DEL
  } cell_act_t;

  // Result of the reduction tree.
  typedef struct packed {
    logic              done;
    logic              hit;
    logic [WORD_W-1:0] data;
  } red_res_t;

endpackage

@@ rtl/ilae_if.sv @@
// Channel interfaces of the indexed list array engine.
`timescale 1ns / 1ps

interface ilae_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic        [6:0]  position;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface ilae_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] read_value;
  logic        [5:0]  found_position;
  logic        [6:0]  entry_count;

  modport source (output valid, output status, output read_value, output found_position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input read_value, input found_position,
                  input entry_count, output ready);
endinterface

interface ilae_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ilae_cell.sv @@
// One cell of the list chain: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module ilae_cell
  import ilae_pkg::*;
#(
  parameter int IDX = 0,
  parameter int AW  = 6
) (
  input  logic              clk,
  input  cell_act_t         act,
  input  logic [AW-1:0]     tgt,
  input  logic [WORD_W-1:0] wr_value,
  input  logic [WORD_W-1:0] left_q,
  input  logic [WORD_W-1:0] right_q,
  input  logic [WORD_W-1:0] key,
  output logic [WORD_W-1:0] data_q,
  output logic              eq
);

  localparam logic [AW-1:0] MY = AW'(IDX);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (act)
      CELL_WRITE: begin
        if (MY == tgt) data_nxt = wr_value;
      end
      // Insert opens a hole at the target by moving every later entry up.
      CELL_INS: begin
        if (MY > tgt) data_nxt = left_q;
        else if (MY == tgt) data_nxt = wr_value;
      end
      CELL_DEL: begin
        if (MY >= tgt) data_nxt = right_q;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  assign eq     = (data_r == key);

endmodule

@@ rtl/ilae_reduce.sv @@
// Registered pairwise reduction that finds the first flagged cell one tree level at a time.
`timescale 1ns / 1ps

module ilae_reduce
  import ilae_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              leaf_hit  [DEPTH],
  input  logic [WORD_W-1:0] leaf_data [DEPTH],
  output red_res_t          res
);

  localparam int AW     = $clog2(DEPTH);
  localparam int LEAVES = 1 << AW;
  localparam int LVL_W  = $clog2(AW + 1);

  logic              hit_r  [LEAVES];
  logic [WORD_W-1:0] data_r [LEAVES];
  logic [LVL_W-1:0]  lvl_r;
  logic              busy_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      lvl_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      lvl_r  <= '0;
    end else if (busy_r) begin
      lvl_r <= lvl_r + LVL_W'(1);
      if (lvl_r == LVL_W'(AW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Each level merges neighboring pairs; the lower one wins so the first hit survives.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < LEAVES; k++) begin
        if (k < DEPTH) begin
          hit_r[k]  <= leaf_hit[k];
          data_r[k] <= leaf_data[k];
        end else begin
          hit_r[k]  <= 1'b0;
          data_r[k] <= '0;
        end
      end
    end else if (busy_r) begin
      for (int k = 0; k < LEAVES / 2; k++) begin
        hit_r[k]  <= hit_r[2*k] | hit_r[2*k+1];
        data_r[k] <= hit_r[2*k] ? data_r[2*k] : data_r[2*k+1];
      end
    end
  end

  assign res.done = done_r;
  assign res.hit  = hit_r[0];
  assign res.data = data_r[0];

endmodule

@@ rtl/indexed_list_array_engine.sv @@
// Top level of the indexed list array engine.
//
// Requests arrive as words on in_ch (opcode, position, value) and every request
// produces exactly one result word on out_ch (status, read_value, found_position,
// entry_count). Both channels hand over a word when valid and ready are high.
// cfg_ch writes the capacity register and is always ready; write it only while idle.
// The entries live in a chain of DEPTH cells. Append, insert, delete and edit shift or
// write the cells in the accepting cycle, and their result is registered in that same
// cycle, so a new request can be taken every cycle while the receiver keeps up.
// Search and a valid read flag their cells at once and then find the first hit in a
// registered pairwise tree, one level per cycle: the result is registered once the tree
// is done and the result register is free, and no request is taken meanwhile.
// Reset empties the list and sets the capacity to 64; entry contents are not cleared.
// A stalled receiver holds the result register; a new request is taken only when that
// register is free or being emptied in the same cycle.
`timescale 1ns / 1ps

module indexed_list_array_engine
  import ilae_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  ilae_in_if.sink    in_ch,
  ilae_out_if.source out_ch,
  ilae_cfg_if.sink   cfg_ch
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int W     = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [W-1:0] DEPTH_W = W'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [6:0]       cap_r;
  logic             search_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [WORD_W-1:0] out_read_r;
  logic [5:0]        out_found_r;
  logic [6:0]        out_count_r;

  logic [W-1:0]  count_w;
  logic [W-1:0]  pos_w;
  logic [W-1:0]  cap_w;
  logic [W-1:0]  cap_eff;
  logic          out_free;
  logic          out_load;
  logic          in_acc;
  logic          need_tree;
  logic [1:0]    status;
  cell_act_t     act;
  cell_act_t     cell_act;
  logic [AW-1:0] tgt;

  logic [WORD_W-1:0] cell_q    [DEPTH];
  logic              cell_eq   [DEPTH];
  logic              leaf_hit  [DEPTH];
  logic [WORD_W-1:0] leaf_data [DEPTH];
  red_res_t          red;

  assign count_w  = W'(count_r);
  assign pos_w    = W'(in_ch.position);
  assign cap_w    = W'(cap_r);
  assign cap_eff  = (cap_w < DEPTH_W) ? cap_w : DEPTH_W;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // The result register is refilled in this cycle.
  assign out_load = (in_acc && !need_tree) || ((state_r == S_SCAN) && red.done && out_free);

  // Request decode: bounds and capacity checks, and the action for the cell chain.
  always_comb begin
    need_tree = 1'b0;
    status    = ST_OK;
    act       = CELL_HOLD;
    tgt       = '0;
    count_nxt = count_r;
    unique case (in_ch.opcode)
      OP_APPEND: begin
        if (count_w >= cap_eff) begin
          status = ST_OVERFLOW;
        end else begin
          act       = CELL_WRITE;
          tgt       = count_w[AW-1:0];
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (pos_w > count_w) begin
          status = ST_BAD_INDEX;
        end else if (count_w >= cap_eff) begin
          status = ST_OVERFLOW;
        end else begin
          act       = CELL_INS;
          tgt       = pos_w[AW-1:0];
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_w >= count_w) begin
          status = ST_BAD_INDEX;
        end else begin
          act       = CELL_DEL;
          tgt       = pos_w[AW-1:0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_SEARCH: begin
        need_tree = 1'b1;
      end
      OP_EDIT: begin
        if (pos_w >= count_w) begin
          status = ST_BAD_INDEX;
        end else begin
          act = CELL_WRITE;
          tgt = pos_w[AW-1:0];
        end
      end
      OP_READ: begin
        if (pos_w >= count_w) status = ST_BAD_INDEX;
        else need_tree = 1'b1;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign cell_act = in_acc ? act : CELL_HOLD;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_d;
    logic [WORD_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_q[i+1];
    end

    ilae_cell #(
      .IDX (i),
      .AW  (AW)
    ) u_cell (
      .clk      (clk),
      .act      (cell_act),
      .tgt      (tgt),
      .wr_value (in_ch.value),
      .left_q   (left_d),
      .right_q  (right_d),
      .key      (in_ch.value),
      .data_q   (cell_q[i]),
      .eq       (cell_eq[i])
    );

    // A search leaf carries its own index; a read leaf carries the entry itself.
    assign leaf_hit[i]  = (in_ch.opcode == OP_SEARCH) ? (cell_eq[i] && (W'(i) < count_w))
                                                      : (W'(i) == pos_w);
    assign leaf_data[i] = (in_ch.opcode == OP_SEARCH) ? WORD_W'(i) : cell_q[i];
  end

  ilae_reduce #(
    .DEPTH (DEPTH)
  ) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc && need_tree),
    .leaf_hit  (leaf_hit),
    .leaf_data (leaf_data),
    .res       (red)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            count_r <= count_nxt;
            if (need_tree) begin
              state_r  <= S_SCAN;
              search_r <= (in_ch.opcode == OP_SEARCH);
            end else begin
              out_valid_r  <= 1'b1;
              out_status_r <= status;
              out_read_r   <= '0;
              out_found_r  <= '0;
              out_count_r  <= 7'(count_nxt);
            end
          end
        end
        S_SCAN: begin
          if (red.done && out_free) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_count_r <= 7'(count_r);
            if (search_r) begin
              out_status_r <= red.hit ? ST_OK : ST_NOT_FOUND;
              out_read_r   <= '0;
              out_found_r  <= red.hit ? red.data[5:0] : 6'd0;
            end else begin
              out_status_r <= ST_OK;
              out_read_r   <= red.data;
              out_found_r  <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.read_value     = out_read_r;
  assign out_ch.found_position = out_found_r;
  assign out_ch.entry_count    = out_count_r;

endmodule
